// File: hw/rtl/ifl_pkg.sv
`default_nettype none

package ifl_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int LNK_W      = $clog2(MAX_BLOCKS + 1);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] alloc_index;
      logic [1:0]       status;
      logic             is_empty;
      logic [CNT_W-1:0] free_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/ifl_link_ram.sv
`default_nettype none

module ifl_link_ram (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ifl_pkg::IDX_W-1:0] rd_addr,
   output logic [ifl_pkg::LNK_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [ifl_pkg::IDX_W-1:0] wr_addr,
   input  logic [ifl_pkg::LNK_W-1:0] wr_data
);
   import ifl_pkg::*;

   logic [LNK_W-1:0] mem [MAX_BLOCKS];
   logic [LNK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/index_free_list_allocator_core.sv
`default_nettype none

// Block pool kept as a linked free list of indices in a single link memory.
// Allocate and deallocate: the item is accepted and the link entry at the
// head is read, then the result is formed and the head, free counter and,
// on a free, link entry are updated once the result register is free.
// Reinitialize writes one link entry per cycle, min(capacity, 1024) entries
// in all. A result waiting on rsp_stall does not stop the next request
// being accepted; that request waits in its execute state until the result
// is taken. Link entries are not cleared at reset; the pool starts empty and
// capacity reads 0, so a reinitialize is needed before any allocation.
module index_free_list_allocator_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ifl_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ifl_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ifl_pkg::CNT_W-1:0] csr_data
);
   import ifl_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_INIT = 2'd2;

   localparam logic [LNK_W-1:0] NULL_LNK = LNK_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);

   logic [1:0]       state_ff, state_in;
   logic [1:0]       cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [LNK_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] pool_ff, pool_in;
   logic [CNT_W-1:0] cap_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, res;

   logic             accept, out_free, commit, head_null, walk_last, free_ok;
   logic [CNT_W-1:0] init_n;
   logic [LNK_W-1:0] rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [LNK_W-1:0] wr_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == S_EXEC) && out_free;
   assign head_null = (head_ff == NULL_LNK);
   assign init_n    = (cap_ff > MAX_CNT) ? MAX_CNT : cap_ff;
   assign walk_last = (CNT_W'(ptr_ff) == init_n - CNT_W'(1));
   assign free_ok   = (CNT_W'(idx_ff) < pool_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      res     = '0;
      head_in = head_ff;
      free_in = free_ff;
      pool_in = pool_ff;
      case (cmd_ff)
         CMD_ALLOC: begin
            if (head_null) begin
               res.status = ST_EMPTY;
            end else begin
               res.granted     = 1'b1;
               res.alloc_index = head_ff[IDX_W-1:0];
               head_in         = (rd_data > NULL_LNK) ? NULL_LNK : rd_data;
               free_in         = (free_ff != '0) ? free_ff - CNT_W'(1) : free_ff;
            end
         end
         CMD_FREE: begin
            if (!free_ok) begin
               res.status = ST_RANGE;
            end else begin
               head_in = LNK_W'(idx_ff);
               free_in = (free_ff < MAX_CNT) ? free_ff + CNT_W'(1) : free_ff;
            end
         end
         CMD_INIT: begin
            pool_in = init_n;
            free_in = init_n;
            head_in = (init_n == '0) ? NULL_LNK : '0;
         end
         default: begin
         end
      endcase
      res.is_empty   = (head_in == NULL_LNK);
      res.free_count = free_in;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = head_ff;
      if (state_ff == S_INIT) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         wr_data = walk_last ? NULL_LNK : LNK_W'(ptr_ff) + LNK_W'(1);
      end else if (commit && (cmd_ff == CMD_FREE) && free_ok) begin
         wr_en = 1'b1;
      end
   end

   ifl_link_ram u_link_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = ((req_data.cmd == CMD_INIT) && (init_n != '0)) ? S_INIT : S_EXEC;
            end
         end
         S_INIT: begin
            if (walk_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LNK;
         free_ff      <= '0;
         pool_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (commit) begin
            head_ff      <= head_in;
            free_ff      <= free_in;
            pool_ff      <= pool_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data.cmd;
         idx_ff <= req_data.block_index;
         ptr_ff <= '0;
      end else if (state_ff == S_INIT) begin
         ptr_ff <= ptr_ff + IDX_W'(1);
      end
      if (commit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sanity checks
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("item accepted while another is in flight");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NULL_LNK)
      else $error("head beyond null marker");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (free_ff <= MAX_CNT) && (pool_ff <= MAX_CNT))
      else $error("counter beyond pool limit");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> (CNT_W'(ptr_ff) < init_n))
      else $error("link walk past pool size");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !commit)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire
